// ----- hdl/rirc_pkg.sv -----
// Shared types and constants for the row interval rectangle coalescer.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package rirc_pkg;

   localparam int SLOT_W = 16;

   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_ADD     = 2'd1;
   localparam logic [1:0] MODE_EXTRACT = 2'd2;

   localparam logic [6:0]        ROW_OFFSET_RESET = 7'd41;
   localparam logic [SLOT_W-1:0] EMPTY_SLOT       = '0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_CHK,
      ST_ADD_EV,
      ST_X_RD,
      ST_X_EV,
      ST_X_RECT,
      ST_O_RD,
      ST_O_EV,
      ST_X_FIN
   } state_type;

endpackage

// ----- hdl/row_interval_rect_coalescer.sv -----
// Top level of the row interval rectangle coalescer: store, sequencer and
// result register. Depends on rirc_pkg.
`timescale 1ns / 1ps

// The obstacle map sits in one synchronous memory holding one map row per
// word (SLOTS packed intervals). An add or extract reads a row, then
// modifies and writes that row back where it changes. After reset, and for
// a clear transaction, the block sweeps all ROWS rows (172 by default) and
// accepts no request meanwhile. An add merges its interval into each
// covered row inside the store and steps over covered rows outside it. An
// extract scans rows from the top row of the previous rectangle; with
// MAX_RECTS rectangles made, a further scan of the remaining rows decides
// the overflow flag. Results leave through an output register; the last
// rectangle is held back until the block knows it is the last one.
module row_interval_rect_coalescer #(
   parameter int ROWS      = 172,
   parameter int SLOTS     = 5,
   parameter int MAX_RECTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_x_left,
   input  logic [7:0] req_x_right,
   input  logic [7:0] req_y_top,
   input  logic [7:0] req_y_bottom,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_rect_valid,
   output logic [7:0] rsp_rect_x_left,
   output logic [7:0] rsp_rect_x_right,
   output logic [7:0] rsp_rect_y_top,
   output logic [7:0] rsp_rect_y_bottom,
   output logic [4:0] rsp_rect_count,
   output logic       rsp_overflow,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_row_offset
);
   import rirc_pkg::*;

   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW = $clog2(ROWS + 1);
   localparam int KW = $clog2(MAX_RECTS + 1);
   localparam int RW = SLOTS * SLOT_W;

   logic [RW-1:0] mem [ROWS];
   logic [RW-1:0] mem_q;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [RW-1:0] mem_wd;

   state_type state_ff, state_in;

   logic [6:0]        off_ff;
   logic [CW-1:0]     row_ff, row_in;
   logic [CW-1:0]     top_ff, top_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic              forming_ff, forming_in;
   logic              occ_ff, occ_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [7:0]        y_ff, y_in;
   logic [7:0]        s_ff, s_in, e_ff, e_in, yb_ff, yb_in;

   // Pending rectangle, held until the next one is found or the scan ends.
   logic       pend_ff, pend_in;
   logic [7:0] p_xl_ff, p_xl_in, p_xr_ff, p_xr_in;
   logic [7:0] p_yt_ff, p_yt_in, p_yb_ff, p_yb_in;
   logic [4:0] p_cnt_ff, p_cnt_in;

   logic       o_valid_ff, o_valid_in;
   logic       o_rv_ff, o_rv_in, o_ovf_ff, o_ovf_in, o_last_ff, o_last_in;
   logic [7:0] o_xl_ff, o_xl_in, o_xr_ff, o_xr_in, o_yt_ff, o_yt_in, o_yb_ff, o_yb_in;
   logic [4:0] o_cnt_ff, o_cnt_in;

   logic          out_free;
   logic          req_acc;
   logic [8:0]    y_diff;
   logic          y_in_store;
   logic          row_end;
   logic [RW-1:0] add_row, clr_nz_row, clr_eq_row;
   logic          nz_found, eq_found, any_nz;

   assign out_free  = !o_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign y_diff    = {1'b0, y_ff} - {2'b00, off_ff};
   assign y_in_store = !y_diff[8] && (y_diff[7:0] < 8'(ROWS));
   assign row_end   = (row_ff == CW'(ROWS));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q <= mem[mem_ra];
   end

   // Merge of the add interval into the row just read.
   always_comb begin
      logic              done;
      logic [SLOT_W-1:0] v;
      logic [7:0]        ts, te;
      add_row = mem_q;
      done    = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         v  = mem_q[j*SLOT_W +: SLOT_W];
         ts = v[15:8];
         te = v[7:0];
         if (!done) begin
            if (v == EMPTY_SLOT) begin
               add_row[j*SLOT_W +: SLOT_W] = {s_ff, e_ff};
               done = 1'b1;
            end else if (ts <= e_ff && ts > s_ff) begin
               add_row[j*SLOT_W +: SLOT_W] = {s_ff, te};
               done = 1'b1;
            end else if (te < e_ff && te >= s_ff) begin
               add_row[j*SLOT_W +: SLOT_W] = {ts, e_ff};
               done = 1'b1;
            end else if (ts <= s_ff && te >= e_ff) begin
               done = 1'b1;
            end else if (s_ff < ts && e_ff > te) begin
               add_row[j*SLOT_W +: SLOT_W] = {s_ff, e_ff};
               done = 1'b1;
            end
         end
      end
   end

   // First occupied slot and first slot equal to the running interval.
   always_comb begin
      logic [SLOT_W-1:0] v;
      clr_nz_row = mem_q;
      clr_eq_row = mem_q;
      nz_found   = 1'b0;
      eq_found   = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         v = mem_q[j*SLOT_W +: SLOT_W];
         if (!nz_found && v != EMPTY_SLOT) begin
            clr_nz_row[j*SLOT_W +: SLOT_W] = EMPTY_SLOT;
            nz_found = 1'b1;
         end
         if (!eq_found && v != EMPTY_SLOT && v == cur_ff) begin
            clr_eq_row[j*SLOT_W +: SLOT_W] = EMPTY_SLOT;
            eq_found = 1'b1;
         end
      end
   end

   // The first occupied slot found this way also starts the next rectangle.
   logic [SLOT_W-1:0] first_nz;
   always_comb begin
      first_nz = EMPTY_SLOT;
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (mem_q[j*SLOT_W +: SLOT_W] != EMPTY_SLOT) begin
            first_nz = mem_q[j*SLOT_W +: SLOT_W];
         end
      end
   end
   assign any_nz = nz_found;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (row_ff == CW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_mode)
                  MODE_CLEAR:   state_in = ST_CLEAR;
                  MODE_ADD:     state_in = ST_ADD_CHK;
                  MODE_EXTRACT: state_in = ST_X_RD;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_CHK: begin
            if (y_ff >= yb_ff) begin
               state_in = ST_IDLE;
            end else if (y_in_store) begin
               state_in = ST_ADD_EV;
            end
         end
         ST_ADD_EV: state_in = ST_ADD_CHK;
         ST_X_RD: begin
            if (row_end) begin
               state_in = forming_ff ? ST_X_RECT : ST_X_FIN;
            end else begin
               state_in = ST_X_EV;
            end
         end
         ST_X_EV: begin
            if (forming_ff && !eq_found) begin
               state_in = ST_X_RECT;
            end else begin
               state_in = ST_X_RD;
            end
         end
         ST_X_RECT: begin
            if (!pend_ff || out_free) begin
               state_in = (k_ff == KW'(MAX_RECTS - 1)) ? ST_O_RD : ST_X_RD;
            end
         end
         ST_O_RD: state_in = row_end ? ST_X_FIN : ST_O_EV;
         ST_O_EV: state_in = any_nz ? ST_X_FIN : ST_O_RD;
         ST_X_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory control, datapath and result register loads.
   always_comb begin
      mem_we     = 1'b0;
      mem_wa     = row_ff[AW-1:0];
      mem_ra     = row_ff[AW-1:0];
      mem_wd     = '0;
      row_in     = row_ff;
      top_in     = top_ff;
      cur_in     = cur_ff;
      forming_in = forming_ff;
      occ_in     = occ_ff;
      k_in       = k_ff;
      y_in       = y_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      yb_in      = yb_ff;
      pend_in    = pend_ff;
      p_xl_in    = p_xl_ff;
      p_xr_in    = p_xr_ff;
      p_yt_in    = p_yt_ff;
      p_yb_in    = p_yb_ff;
      p_cnt_in   = p_cnt_ff;
      o_valid_in = o_valid_ff && !rsp_ready;
      o_rv_in    = o_rv_ff;
      o_xl_in    = o_xl_ff;
      o_xr_in    = o_xr_ff;
      o_yt_in    = o_yt_ff;
      o_yb_in    = o_yb_ff;
      o_cnt_in   = o_cnt_ff;
      o_ovf_in   = o_ovf_ff;
      o_last_in  = o_last_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            row_in = (row_ff == CW'(ROWS - 1)) ? '0 : row_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_acc) begin
               row_in     = '0;
               y_in       = req_y_top;
               s_in       = req_x_left;
               e_in       = req_x_right;
               yb_in      = req_y_bottom;
               forming_in = 1'b0;
               occ_in     = 1'b0;
               k_in       = '0;
               pend_in    = 1'b0;
            end
         end
         ST_ADD_CHK: begin
            mem_ra = y_diff[AW-1:0];
            mem_wa = y_diff[AW-1:0];
            if (y_ff < yb_ff && !y_in_store) begin
               y_in = y_ff + 8'd1;
            end
         end
         ST_ADD_EV: begin
            mem_ra = y_diff[AW-1:0];
            mem_wa = y_diff[AW-1:0];
            mem_we = 1'b1;
            mem_wd = add_row;
            y_in   = y_ff + 8'd1;
         end
         ST_X_RD, ST_O_RD: begin
         end
         ST_X_EV: begin
            if (!forming_ff) begin
               row_in = row_ff + 1'b1;
               if (nz_found) begin
                  mem_we     = 1'b1;
                  mem_wd     = clr_nz_row;
                  cur_in     = first_nz;
                  top_in     = row_ff;
                  forming_in = 1'b1;
               end
            end else if (eq_found) begin
               mem_we = 1'b1;
               mem_wd = clr_eq_row;
               row_in = row_ff + 1'b1;
            end
         end
         ST_X_RECT: begin
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  o_valid_in = 1'b1;
                  o_rv_in    = 1'b1;
                  o_xl_in    = p_xl_ff;
                  o_xr_in    = p_xr_ff;
                  o_yt_in    = p_yt_ff;
                  o_yb_in    = p_yb_ff;
                  o_cnt_in   = p_cnt_ff;
                  o_ovf_in   = 1'b0;
                  o_last_in  = 1'b0;
               end
               pend_in    = 1'b1;
               p_xl_in    = cur_ff[15:8];
               p_xr_in    = cur_ff[7:0];
               p_yt_in    = 8'(top_ff) + {1'b0, off_ff};
               p_yb_in    = 8'(row_ff) + {1'b0, off_ff};
               p_cnt_in   = 5'(k_ff + 1'b1);
               k_in       = k_ff + 1'b1;
               forming_in = 1'b0;
               row_in     = top_ff;
            end
         end
         ST_O_EV: begin
            row_in = row_ff + 1'b1;
            if (any_nz) begin
               occ_in = 1'b1;
            end
         end
         ST_X_FIN: begin
            if (out_free) begin
               o_valid_in = 1'b1;
               o_last_in  = 1'b1;
               o_ovf_in   = pend_ff && occ_ff;
               o_rv_in    = pend_ff;
               o_xl_in    = pend_ff ? p_xl_ff : 8'd0;
               o_xr_in    = pend_ff ? p_xr_ff : 8'd0;
               o_yt_in    = pend_ff ? p_yt_ff : 8'd0;
               o_yb_in    = pend_ff ? p_yb_ff : 8'd0;
               o_cnt_in   = pend_ff ? p_cnt_ff : 5'd0;
               pend_in    = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         off_ff     <= ROW_OFFSET_RESET;
         row_ff     <= '0;
         forming_ff <= 1'b0;
         occ_ff     <= 1'b0;
         k_ff       <= '0;
         pend_ff    <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         if (csr_valid && csr_ready) begin
            off_ff <= csr_row_offset;
         end
         row_ff     <= row_in;
         forming_ff <= forming_in;
         occ_ff     <= occ_in;
         k_ff       <= k_in;
         pend_ff    <= pend_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      cur_ff    <= cur_in;
      y_ff      <= y_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      yb_ff     <= yb_in;
      p_xl_ff   <= p_xl_in;
      p_xr_ff   <= p_xr_in;
      p_yt_ff   <= p_yt_in;
      p_yb_ff   <= p_yb_in;
      p_cnt_ff  <= p_cnt_in;
      o_rv_ff   <= o_rv_in;
      o_xl_ff   <= o_xl_in;
      o_xr_ff   <= o_xr_in;
      o_yt_ff   <= o_yt_in;
      o_yb_ff   <= o_yb_in;
      o_cnt_ff  <= o_cnt_in;
      o_ovf_ff  <= o_ovf_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_rect_valid    = o_rv_ff;
   assign rsp_rect_x_left   = o_xl_ff;
   assign rsp_rect_x_right  = o_xr_ff;
   assign rsp_rect_y_top    = o_yt_ff;
   assign rsp_rect_y_bottom = o_yb_ff;
   assign rsp_rect_count    = o_cnt_ff;
   assign rsp_overflow      = o_ovf_ff;
   assign rsp_last          = o_last_ff;

endmodule

// ----- hdl/rirc_checker.sv -----
// Port-level checks for the row interval rectangle coalescer, and the bind
// that attaches them to the top level. Depends on the top level's ports.
`timescale 1ns / 1ps

module rirc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_rect_valid,
   input logic [7:0] rsp_rect_x_left,
   input logic [4:0] rsp_rect_count,
   input logic       rsp_overflow,
   input logic       rsp_last
);

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rect_x_left)
         && $stable(rsp_rect_count) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Only the final result of an extract may be empty.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rect_valid |-> rsp_last && rsp_rect_count == 5'd0
         && !rsp_overflow)
      else $error("empty result not final or not cleared");

   // Overflow is reported on the last rectangle only.
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_last && rsp_rect_valid)
      else $error("overflow on a non-final result");

   // A rectangle carries a non-zero running count.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rect_valid |-> rsp_rect_count != 5'd0)
      else $error("rectangle with zero count");

endmodule

bind row_interval_rect_coalescer rirc_checker u_rirc_checker (.*);
